// File: src/ramst_pkg.sv
// Package: shared types, constants and helpers for the range-add max segment tree.
`timescale 1ns / 1ps
package ramst_pkg;
	localparam int MaxLeavesDefault = 1024;
	localparam int NodeCountDefault = 4096;
	localparam int LeafW = 11;
	localparam int DeltaW = 16;
	localparam int ValW = 32;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_IGNORED = 2'd1;
	localparam logic [1:0] STATUS_WRAPPED = 2'd2;

	typedef struct packed {
		logic [LeafW-1:0] range_low;
		logic [LeafW-1:0] range_high;
		logic signed [DeltaW-1:0] delta;
	} in_beat_t;

	typedef struct packed {
		logic signed [ValW-1:0] global_max;
		logic [1:0] status;
	} out_beat_t;

	// Signed 32-bit add that wraps; reports whether the true sum left the range.
	function automatic logic [ValW:0] add_wrap(input logic [ValW-1:0] a,
			input logic [ValW-1:0] b);
		logic [ValW-1:0] s;
		logic ovf;
		s = a + b;
		ovf = (a[ValW-1] == b[ValW-1]) && (s[ValW-1] != a[ValW-1]);
		return {ovf, s};
	endfunction
endpackage

// File: src/range_add_max_segment_tree_core.sv
// Top level: sequenced range-add / global-max segment tree over an on-chip node store.
// Flow: the beat is taken in IDLE, the tree walk W runs, ST_ROOT reads the root, and ST_OUT
//   raises out_valid. In W a fully covered node passes VISIT, RDNODE, COVER, COVW and POP;
//   a partly covered node descends into the children that overlap, then RDL, RDR, RDC, FIX
//   and POP. A node past the store passes VISIT and POP only. A bad range skips W.
// Throughput: one beat at a time. in_stall stays high until the result beat is taken.
// Reset: asynchronous active low. leaves_q returns to MAX_LEAVES, capped at 2047; then a
//   clearing pass zeroes all NODE_COUNT nodes (4096 by default) while in_stall holds high.
`timescale 1ns / 1ps
module range_add_max_segment_tree_core
	import ramst_pkg::*;
#(
	parameter int MAX_LEAVES = MaxLeavesDefault,
	parameter int NODE_COUNT = NodeCountDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [LeafW-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_beat_t out_data
);
	localparam int NW = $clog2(NODE_COUNT);
	// Index width wide enough to hold 2*o+1 for any node touched.
	localparam int OW = NW + 2;
	localparam int DEPTH = $clog2(MAX_LEAVES) + 2;
	localparam int SW = $clog2(DEPTH);
	localparam int PW = (LeafW > $clog2(MAX_LEAVES + 1)) ? LeafW : $clog2(MAX_LEAVES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_VISIT = 4'd1;
	localparam logic [3:0] ST_RDNODE = 4'd2;
	localparam logic [3:0] ST_COVER = 4'd3;
	localparam logic [3:0] ST_RDL = 4'd4;
	localparam logic [3:0] ST_RDR = 4'd5;
	localparam logic [3:0] ST_FIX = 4'd6;
	localparam logic [3:0] ST_POP = 4'd7;
	localparam logic [3:0] ST_ROOT = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;
	localparam logic [3:0] ST_RDC = 4'd10;
	localparam logic [3:0] ST_COVW = 4'd11;
	localparam logic [3:0] ST_CLEAR = 4'd12;

	// Store: cover and max per node, zeroed by the clearing pass after reset.
	logic [ValW-1:0] cov_mem [NODE_COUNT];
	logic [ValW-1:0] max_mem [NODE_COUNT];
	logic [NW-1:0] clr_q;

	logic [3:0] state_q;
	logic [LeafW-1:0] leaves_q;
	logic [PW-1:0] n_eff;
	logic [PW-1:0] ql_q, qr_q;
	logic [ValW-1:0] d_q;
	logic ovf_q;

	// Recursion stack: per frame node, span, and which children are done.
	logic [OW-1:0] stk_o [DEPTH];
	logic [PW-1:0] stk_lo [DEPTH];
	logic [PW-1:0] stk_hi [DEPTH];
	logic [1:0] stk_ph [DEPTH];
	logic [SW-1:0] sp_q;

	logic [OW-1:0] cur_o;
	logic [PW-1:0] cur_lo, cur_hi, mid;
	logic [1:0] cur_ph;

	// Store access.
	logic rd_en;
	logic [OW-1:0] rd_addr;
	logic [ValW-1:0] rd_cov_q, rd_max_q;
	logic wr_en;
	logic [OW-1:0] wr_addr;
	logic [ValW-1:0] wr_cov, wr_max;

	// Shared adder.
	logic [ValW-1:0] add_a, add_b;
	logic [ValW:0] add_r;
	logic [ValW-1:0] mx_a_q;
	logic [ValW-1:0] cov_new_q;

	assign add_r = add_wrap(add_a, add_b);

	always_comb begin
		n_eff = PW'(leaves_q);
		if (leaves_q == '0) n_eff = PW'(1);
		if (PW'(leaves_q) > PW'(MAX_LEAVES)) n_eff = PW'(MAX_LEAVES);
	end

	assign cur_o = stk_o[sp_q[SW-1:0]];
	assign cur_lo = stk_lo[sp_q];
	assign cur_hi = stk_hi[sp_q];
	assign cur_ph = stk_ph[sp_q];
	assign mid = PW'(({1'b0, cur_lo} + {1'b0, cur_hi}) >> 1);

	// Reads past the store come back as zero from the read register.
	logic [ValW-1:0] r_cov, r_max;
	assign r_cov = rd_cov_q;
	assign r_max = rd_max_q;

	logic [ValW-1:0] big;
	assign big = ($signed(mx_a_q) > $signed(r_max)) ? mx_a_q : r_max;

	// Address, write data and adder operand selection per state.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = cur_o;
		wr_en = 1'b0;
		wr_addr = cur_o;
		wr_cov = r_cov;
		wr_max = add_r[ValW-1:0];
		add_a = r_cov;
		add_b = d_q;
		unique case (state_q)
			ST_RDNODE: begin
				rd_en = 1'b1;
			end
			ST_RDL: begin
				rd_en = 1'b1;
				rd_addr = OW'({cur_o, 1'b0});
			end
			ST_RDR: begin
				rd_en = 1'b1;
				rd_addr = OW'({cur_o, 1'b1});
			end
			ST_RDC: begin
				rd_en = 1'b1;
			end
			ST_ROOT: begin
				rd_en = 1'b1;
				rd_addr = OW'(1);
			end
			// Covered node: cover sum was formed last cycle, now form the max sum.
			ST_COVW: begin
				add_a = r_max;
				wr_en = 1'b1;
				wr_cov = cov_new_q;
			end
			// Partly covered node: max of the children plus own cover.
			ST_FIX: begin
				add_a = mx_a_q;
				add_b = r_cov;
				wr_en = 1'b1;
			end
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = OW'(clr_q);
				wr_cov = '0;
				wr_max = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en && rd_addr < OW'(NODE_COUNT)) begin
			rd_cov_q <= cov_mem[rd_addr[NW-1:0]];
			rd_max_q <= max_mem[rd_addr[NW-1:0]];
		end else if (rd_en) begin
			rd_cov_q <= '0;
			rd_max_q <= '0;
		end
		if (wr_en && wr_addr < OW'(NODE_COUNT)) begin
			cov_mem[wr_addr[NW-1:0]] <= wr_cov;
			max_mem[wr_addr[NW-1:0]] <= wr_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			leaves_q <= LeafW'(MAX_LEAVES > 2047 ? 2047 : MAX_LEAVES);
			sp_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
			ql_q <= '0;
			qr_q <= '0;
			d_q <= '0;
			mx_a_q <= '0;
			cov_new_q <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				stk_o[i] <= '0;
				stk_lo[i] <= '0;
				stk_hi[i] <= '0;
				stk_ph[i] <= '0;
			end
		end else begin
			if (cfg_we) leaves_q <= cfg_wdata;
			unique case (state_q)
				// Zero one node per cycle, then open the input.
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NW'(NODE_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						ql_q <= PW'(in_data.range_low);
						qr_q <= PW'(in_data.range_high);
						d_q <= ValW'(in_data.delta);
						ovf_q <= 1'b0;
						sp_q <= '0;
						stk_o[0] <= OW'(1);
						stk_lo[0] <= PW'(1);
						stk_hi[0] <= n_eff;
						stk_ph[0] <= 2'd0;
						if (in_data.range_low == '0 || in_data.range_low > in_data.range_high
								|| PW'(in_data.range_high) > n_eff) begin
							out_data.status <= STATUS_IGNORED;
							state_q <= ST_ROOT;
						end else begin
							out_data.status <= STATUS_OK;
							state_q <= ST_VISIT;
						end
					end
				end
				ST_VISIT: begin
					if (cur_o >= OW'(NODE_COUNT)) state_q <= ST_POP;
					else state_q <= ST_RDNODE;
				end
				ST_RDNODE: begin
					if (ql_q <= cur_lo && cur_hi <= qr_q) state_q <= ST_COVER;
					else begin
						// Descend into the children that overlap.
						if (cur_ph == 2'd0 && ql_q <= mid) begin
							stk_ph[sp_q] <= 2'd1;
							stk_o[sp_q + 1'b1] <= OW'({cur_o, 1'b0});
							stk_lo[sp_q + 1'b1] <= cur_lo;
							stk_hi[sp_q + 1'b1] <= mid;
							stk_ph[sp_q + 1'b1] <= 2'd0;
							sp_q <= sp_q + 1'b1;
							state_q <= ST_VISIT;
						end else if (cur_ph != 2'd2 && qr_q > mid) begin
							stk_ph[sp_q] <= 2'd2;
							stk_o[sp_q + 1'b1] <= OW'({cur_o, 1'b1});
							stk_lo[sp_q + 1'b1] <= mid + 1'b1;
							stk_hi[sp_q + 1'b1] <= cur_hi;
							stk_ph[sp_q + 1'b1] <= 2'd0;
							sp_q <= sp_q + 1'b1;
							state_q <= ST_VISIT;
						end else state_q <= ST_RDL;
					end
				end
				ST_COVER: begin
					cov_new_q <= add_r[ValW-1:0];
					if (add_r[ValW]) ovf_q <= 1'b1;
					state_q <= ST_COVW;
				end
				ST_COVW: begin
					if (add_r[ValW]) ovf_q <= 1'b1;
					state_q <= ST_POP;
				end
				ST_RDL: state_q <= ST_RDR;
				ST_RDR: begin
					mx_a_q <= r_max;
					state_q <= ST_RDC;
				end
				ST_RDC: begin
					mx_a_q <= big;
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (add_r[ValW]) ovf_q <= 1'b1;
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (sp_q == '0) state_q <= ST_ROOT;
					else begin
						sp_q <= sp_q - 1'b1;
						state_q <= ST_RDNODE;
					end
				end
				ST_ROOT: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid) begin
						out_data.global_max <= r_max;
						if (out_data.status == STATUS_OK && ovf_q)
							out_data.status <= STATUS_WRAPPED;
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data));
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid);
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT);
	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sp_q) < DEPTH);
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= ST_CLEAR);
endmodule
